/* design/ebdd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ebdd_pkg
// Shared types, constants and saturating arithmetic for the energy-detect
// busy-duration tracker.
// ----------------------------------------------------------------------------
package ebdd_pkg;

  // request codes
  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_QUERY  = 2'd1,
    REQ_ERASE  = 2'd2,
    REQ_RSVD   = 2'd3
  } req_e;

  localparam int unsigned TIME_W = 48;
  localparam int unsigned BASE_W = 56;
  localparam int unsigned SUM_W  = 64;

  localparam logic signed [SUM_W-1:0] SUM_MAX  = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN  = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic signed [SUM_W-1:0] BASE_MAX = {{(SUM_W-BASE_W+1){1'b0}},
                                                  {(BASE_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] BASE_MIN = {{(SUM_W-BASE_W+1){1'b1}},
                                                  {(BASE_W-1){1'b0}}};

  // 64-bit add, clamped to the signed range on overflow
  function automatic logic signed [SUM_W-1:0] sat_add(
    input logic signed [SUM_W-1:0] a,
    input logic signed [SUM_W-1:0] b
  );
    logic signed [SUM_W-1:0] s;
    s = a + b;
    if ((a[SUM_W-1] == b[SUM_W-1]) && (s[SUM_W-1] != a[SUM_W-1])) begin
      s = a[SUM_W-1] ? SUM_MIN : SUM_MAX;
    end
    return s;
  endfunction

  // clamp a running sum into the base power range
  function automatic logic signed [BASE_W-1:0] clamp_base(
    input logic signed [SUM_W-1:0] v
  );
    logic signed [SUM_W-1:0] c;
    c = v;
    if (v > BASE_MAX) begin
      c = BASE_MAX;
    end else if (v < BASE_MIN) begin
      c = BASE_MIN;
    end
    return c[BASE_W-1:0];
  endfunction

endpackage
`default_nettype wire

/* design/energy_detect_busy_duration.sv */
`default_nettype none
// Each pass reads and then checks the table entries one at a time.
// Query: busy scan plus walk when busy; append: prune and move (unless receiving), two sorted
// inserts (unless the table is full) and the busy scan. Erase: clears count and base power.
// The event table, with its registered read data, sets the pace; one word at a time.
// Reset clears the event count and the base power and sets the threshold to 630957344;
// the table contents stay undefined until written, no clearing pass is needed.
// ----------------------------------------------------------------------------
// energy_detect_busy_duration
// Time-sorted table of power change events with pruning, sorted insert and a
// busy-duration walk against a configurable energy threshold.
// ----------------------------------------------------------------------------
module energy_detect_busy_duration #(
  parameter int unsigned EVENT_DEPTH = 64,
  parameter int unsigned POWER_BITS  = 48
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [47:0] cfg_energy_threshold_i,
  // request words
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [47:0] now_time_i,
  input  wire logic [47:0] end_time_i,
  input  wire logic [47:0] rx_power_i,
  input  wire logic        receiving_i,
  // result words
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [47:0]      busy_duration_o,
  output logic             busy_now_o,
  output logic             table_full_o
);

  localparam int unsigned TW     = ebdd_pkg::TIME_W;
  localparam int unsigned SW     = ebdd_pkg::SUM_W;
  localparam int unsigned BW     = ebdd_pkg::BASE_W;
  localparam int unsigned DW     = POWER_BITS + 1;
  localparam int unsigned ENT_W  = TW + DW;
  localparam int unsigned IDX_W  = $clog2(EVENT_DEPTH);
  localparam int unsigned CNT_W  = $clog2(EVENT_DEPTH + 1);
  localparam logic [CNT_W:0] DEPTH_C = (CNT_W+1)'(EVENT_DEPTH);
  localparam logic [SW-1:0]  PMASK   = (64'd1 << POWER_BITS) - 64'd1;
  localparam logic [47:0]    THR_RST = 48'd630957344;

  typedef enum logic [4:0] {
    S_IDLE, S_PR_RD, S_PR_CK, S_PR_FIX, S_MV_RD, S_MV_WR, S_FULL,
    S_FA_RD, S_FA_CK, S_SH_RD, S_SH_WR, S_INS, S_BZ_RD, S_BZ_CK,
    S_AFTER, S_QW_RD, S_QW_CK, S_DUR, S_OUT
  } state_e;

  state_e                  state_q;
  ebdd_pkg::req_e          req_q;
  logic [TW-1:0]           now_q, endt_q, end_q;
  logic [DW-1:0]           pw_q;
  logic                    phase_q, busy_q, full_q;
  logic [CNT_W-1:0]        cnt_q, idx_q, cut_q, pos_q;
  logic signed [BW-1:0]    base_q;
  logic signed [SW-1:0]    sum_q;
  logic [47:0]             thr_q, dur_q;

  // table port
  logic                    rd_en, wr_en;
  logic [IDX_W-1:0]        rd_addr, wr_addr;
  logic [ENT_W-1:0]        rd_data, wr_data;

  // decoded read word
  logic [TW-1:0]           rd_time;
  logic signed [SW-1:0]    rd_delta;
  logic signed [SW-1:0]    add_s;
  logic signed [SW-1:0]    base_ext;
  logic signed [SW-1:0]    thr_ext;
  logic [TW-1:0]           target;
  logic [CNT_W:0]          mv_src;
  logic [CNT_W-1:0]        idx_m1;
  logic [SW-1:0]           pw_full;
  logic [DW-1:0]           ins_delta;

  assign rd_time   = rd_data[ENT_W-1:DW];
  assign rd_delta  = {{(SW-DW){rd_data[DW-1]}}, rd_data[DW-1:0]};
  assign add_s     = ebdd_pkg::sat_add(sum_q, rd_delta);
  assign base_ext  = {{(SW-BW){base_q[BW-1]}}, base_q};
  assign thr_ext   = {16'd0, thr_q};
  assign target    = phase_q ? endt_q : now_q;
  assign mv_src    = {1'b0, idx_q} + {1'b0, cut_q};
  assign idx_m1    = idx_q - CNT_W'(1);
  assign pw_full   = {16'd0, rx_power_i} & PMASK;
  assign ins_delta = phase_q ? (-pw_q) : pw_q;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);

  // table access by state
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx_q[IDX_W-1:0];
    wr_en   = 1'b0;
    wr_addr = idx_q[IDX_W-1:0];
    wr_data = rd_data;
    unique case (state_q)
      S_PR_RD, S_FA_RD, S_BZ_RD, S_QW_RD: begin
        rd_en = 1'b1;
      end
      S_MV_RD: begin
        rd_en   = 1'b1;
        rd_addr = mv_src[IDX_W-1:0];
      end
      S_SH_RD: begin
        rd_en   = 1'b1;
        rd_addr = idx_m1[IDX_W-1:0];
      end
      S_MV_WR, S_SH_WR: begin
        wr_en = 1'b1;
      end
      S_INS: begin
        wr_en   = 1'b1;
        wr_addr = pos_q[IDX_W-1:0];
        wr_data = {target, ins_delta};
      end
      default: begin
      end
    endcase
  end

  ebdd_table #(
    .DEPTH  (EVENT_DEPTH),
    .DATA_W (ENT_W)
  ) u_table (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  // threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      thr_q <= cfg_energy_threshold_i;
    end
  end

  // sequencer and result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      req_q           <= ebdd_pkg::REQ_APPEND;
      now_q           <= '0;
      endt_q          <= '0;
      end_q           <= '0;
      pw_q            <= '0;
      phase_q         <= 1'b0;
      busy_q          <= 1'b0;
      full_q          <= 1'b0;
      cnt_q           <= '0;
      idx_q           <= '0;
      cut_q           <= '0;
      pos_q           <= '0;
      base_q          <= '0;
      sum_q           <= '0;
      dur_q           <= '0;
      out_valid_o     <= 1'b0;
      busy_duration_o <= '0;
      busy_now_o      <= 1'b0;
      table_full_o    <= 1'b0;
    end else begin
      // result word taken; S_OUT handles its own reload
      if (out_valid_o && out_ready_i && (state_q != S_OUT)) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            req_q   <= ebdd_pkg::req_e'(req_type_i);
            now_q   <= now_time_i;
            endt_q  <= end_time_i;
            pw_q    <= pw_full[DW-1:0];
            phase_q <= 1'b0;
            full_q  <= 1'b0;
            dur_q   <= '0;
            idx_q   <= '0;
            case (ebdd_pkg::req_e'(req_type_i))
              ebdd_pkg::REQ_APPEND: begin
                sum_q   <= base_ext;
                state_q <= receiving_i ? S_FULL : S_PR_RD;
              end
              ebdd_pkg::REQ_ERASE: begin
                cnt_q   <= '0;
                base_q  <= '0;
                sum_q   <= '0;
                state_q <= S_BZ_RD;
              end
              default: begin
                sum_q   <= base_ext;
                state_q <= S_BZ_RD;
              end
            endcase
          end
        end
        // fold past events into the base power
        S_PR_RD: begin
          state_q <= (idx_q < cnt_q) ? S_PR_CK : S_PR_FIX;
        end
        S_PR_CK: begin
          if (rd_time <= now_q) begin
            sum_q   <= add_s;
            idx_q   <= idx_q + CNT_W'(1);
            state_q <= S_PR_RD;
          end else begin
            state_q <= S_PR_FIX;
          end
        end
        S_PR_FIX: begin
          base_q  <= ebdd_pkg::clamp_base(sum_q);
          cut_q   <= idx_q;
          idx_q   <= '0;
          state_q <= S_MV_RD;
        end
        // move the surviving entries down to the front
        S_MV_RD: begin
          if (mv_src < {1'b0, cnt_q}) begin
            state_q <= S_MV_WR;
          end else begin
            cnt_q   <= cnt_q - cut_q;
            state_q <= S_FULL;
          end
        end
        S_MV_WR: begin
          idx_q   <= idx_q + CNT_W'(1);
          state_q <= S_MV_RD;
        end
        S_FULL: begin
          idx_q <= '0;
          if (({1'b0, cnt_q} + (CNT_W+1)'(2)) > DEPTH_C) begin
            full_q  <= 1'b1;
            sum_q   <= base_ext;
            state_q <= S_BZ_RD;
          end else begin
            state_q <= S_FA_RD;
          end
        end
        // find the first entry after the target time
        S_FA_RD: begin
          if (idx_q < cnt_q) begin
            state_q <= S_FA_CK;
          end else begin
            pos_q   <= idx_q;
            idx_q   <= cnt_q;
            state_q <= S_SH_RD;
          end
        end
        S_FA_CK: begin
          if (rd_time <= target) begin
            idx_q   <= idx_q + CNT_W'(1);
            state_q <= S_FA_RD;
          end else begin
            pos_q   <= idx_q;
            idx_q   <= cnt_q;
            state_q <= S_SH_RD;
          end
        end
        // open a gap at the insert position, top entry first
        S_SH_RD: begin
          state_q <= (idx_q > pos_q) ? S_SH_WR : S_INS;
        end
        S_SH_WR: begin
          idx_q   <= idx_m1;
          state_q <= S_SH_RD;
        end
        S_INS: begin
          cnt_q <= cnt_q + CNT_W'(1);
          idx_q <= '0;
          if (!phase_q) begin
            phase_q <= 1'b1;
            state_q <= S_FA_RD;
          end else begin
            sum_q   <= base_ext;
            state_q <= S_BZ_RD;
          end
        end
        // summed power up to now
        S_BZ_RD: begin
          if (idx_q < cnt_q) begin
            state_q <= S_BZ_CK;
          end else begin
            busy_q  <= (sum_q > thr_ext);
            state_q <= S_AFTER;
          end
        end
        S_BZ_CK: begin
          if (rd_time <= now_q) begin
            sum_q   <= add_s;
            idx_q   <= idx_q + CNT_W'(1);
            state_q <= S_BZ_RD;
          end else begin
            busy_q  <= (sum_q > thr_ext);
            state_q <= S_AFTER;
          end
        end
        S_AFTER: begin
          idx_q <= '0;
          sum_q <= base_ext;
          end_q <= now_q;
          if ((req_q == ebdd_pkg::REQ_QUERY) && busy_q) begin
            state_q <= S_QW_RD;
          end else begin
            state_q <= S_OUT;
          end
        end
        // walk until the power falls below the threshold
        S_QW_RD: begin
          state_q <= (idx_q < cnt_q) ? S_QW_CK : S_DUR;
        end
        S_QW_CK: begin
          sum_q <= add_s;
          end_q <= rd_time;
          idx_q <= idx_q + CNT_W'(1);
          if ((rd_time >= now_q) && (add_s < thr_ext)) begin
            state_q <= S_DUR;
          end else begin
            state_q <= S_QW_RD;
          end
        end
        S_DUR: begin
          dur_q   <= (end_q > now_q) ? (end_q - now_q) : '0;
          state_q <= S_OUT;
        end
        // hand the result word to the output register
        S_OUT: begin
          if (!out_valid_o || out_ready_i) begin
            out_valid_o     <= 1'b1;
            busy_duration_o <= dur_q;
            busy_now_o      <= busy_q;
            table_full_o    <= full_q;
            state_q         <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* design/ebdd_table.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ebdd_table
// Event table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ebdd_table #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned DATA_W = 97,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              rd_en_i,
  input  wire logic [ADDR_W-1:0] rd_addr_i,
  output logic      [DATA_W-1:0] rd_data_o,
  input  wire logic              wr_en_i,
  input  wire logic [ADDR_W-1:0] wr_addr_i,
  input  wire logic [DATA_W-1:0] wr_data_i
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule
`default_nettype wire

/* sim/energy_detect_busy_duration_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// energy_detect_busy_duration_tb
// Drives request words into the busy-duration tracker under random idling
// and stalls. A scoreboard keeps its own copy of the event table and checks
// every result word against its prediction.
// ----------------------------------------------------------------------------
module energy_detect_busy_duration_tb;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam longint unsigned CYCLE_LIMIT = 4000000;
  localparam logic [47:0] THR_RESET = 48'd630957344;

  // predicted tracker state and the queue of expected result words
  class busy_scoreboard;
    logic [47:0] thr;
    logic [47:0] ev_time [TABLE_DEPTH];
    longint      ev_delta [TABLE_DEPTH];
    int          ev_cnt;
    longint      base;
    logic [47:0] want_dur [$];
    logic        want_busy [$];
    logic        want_full [$];
    int          errors;

    function new();
      thr = THR_RESET;
      ev_cnt = 0;
      base = 0;
      errors = 0;
    endfunction

    function longint clamp_add(longint a, longint b);
      longint s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) s = a[63] ? 64'sh8000000000000000
                                                      : 64'sh7fffffffffffffff;
      return s;
    endfunction

    function int first_later(logic [47:0] t);
      int i;
      i = 0;
      while (i < ev_cnt && ev_time[i] <= t) i++;
      return i;
    endfunction

    function void place(int pos, logic [47:0] t, longint d);
      if (ev_cnt >= TABLE_DEPTH || pos > ev_cnt) return;
      for (int k = ev_cnt; k > pos; k--) begin
        ev_time[k] = ev_time[k-1];
        ev_delta[k] = ev_delta[k-1];
      end
      ev_time[pos] = t;
      ev_delta[pos] = d;
      ev_cnt++;
    endfunction

    function bit power_above(logic [47:0] t);
      longint sum;
      sum = base;
      for (int i = 0; i < ev_cnt && ev_time[i] <= t; i++) sum = clamp_add(sum, ev_delta[i]);
      return sum > longint'({16'd0, thr});
    endfunction

    // accepted request word: apply it and queue the expected result
    function void note_request(ebdd_pkg::req_e req, logic [47:0] now, logic [47:0] endt,
                               logic [47:0] pw, logic recv);
      logic [47:0] dur;
      logic        full;
      int          cut;
      longint      b;
      longint      sum;
      logic [47:0] fin;
      dur = '0;
      full = 1'b0;
      case (req)
        ebdd_pkg::REQ_APPEND: begin
          if (!recv) begin
            cut = first_later(now);
            b = base;
            for (int i = 0; i < cut; i++) b = clamp_add(b, ev_delta[i]);
            if (b > 64'sh007fffffffffffff) b = 64'sh007fffffffffffff;
            if (b < -64'sh0080000000000000) b = -64'sh0080000000000000;
            base = b;
            for (int i = cut; i < ev_cnt; i++) begin
              ev_time[i-cut] = ev_time[i];
              ev_delta[i-cut] = ev_delta[i];
            end
            ev_cnt -= cut;
          end
          if (ev_cnt + 2 > TABLE_DEPTH) begin
            full = 1'b1;
          end else begin
            place(recv ? first_later(now) : 0, now, longint'({16'd0, pw}));
            place(first_later(endt), endt, -longint'({16'd0, pw}));
          end
        end
        ebdd_pkg::REQ_QUERY: begin
          if (power_above(now)) begin
            sum = base;
            fin = now;
            for (int i = 0; i < ev_cnt; i++) begin
              sum = clamp_add(sum, ev_delta[i]);
              fin = ev_time[i];
              if (fin < now) continue;
              if (sum < longint'({16'd0, thr})) break;
            end
            dur = (fin > now) ? fin - now : '0;
          end
        end
        ebdd_pkg::REQ_ERASE: begin
          ev_cnt = 0;
          base = 0;
        end
        default: ;
      endcase
      want_dur = {want_dur, dur};
      want_busy = {want_busy, power_above(now)};
      want_full = {want_full, full};
    endfunction

    function void check_result(logic [47:0] dur, logic busy, logic full);
      logic [47:0] d;
      logic        bz;
      logic        fl;
      if (want_dur.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
        return;
      end
      d = want_dur.pop_front();
      bz = want_busy.pop_front();
      fl = want_full.pop_front();
      if (dur !== d) begin
        $error("busy_duration: expected %0d, got %0d", d, dur);
        errors++;
      end
      if (busy !== bz) begin
        $error("busy_now: expected %0b, got %0b", bz, busy);
        errors++;
      end
      if (full !== fl) begin
        $error("table_full: expected %0b, got %0b", fl, full);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [47:0] cfg_energy_threshold_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  req_type_i;
  logic [47:0] now_time_i;
  logic [47:0] end_time_i;
  logic [47:0] rx_power_i;
  logic        receiving_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [47:0] busy_duration_o;
  logic        busy_now_o;
  logic        table_full_o;

  busy_scoreboard sb;
  int          send_idle_pct;
  int          recv_stall_pct;
  bit          hold_kick;
  bit          hold_seen;
  int          hold_left;
  longint unsigned cycles;
  logic [47:0] tcur;

  energy_detect_busy_duration u_dut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_valid_i            (cfg_valid_i),
    .cfg_ready_o            (cfg_ready_o),
    .cfg_energy_threshold_i (cfg_energy_threshold_i),
    .in_valid_i             (in_valid_i),
    .in_ready_o             (in_ready_o),
    .req_type_i             (req_type_i),
    .now_time_i             (now_time_i),
    .end_time_i             (end_time_i),
    .rx_power_i             (rx_power_i),
    .receiving_i            (receiving_i),
    .out_valid_o            (out_valid_o),
    .out_ready_i            (out_ready_i),
    .busy_duration_o        (busy_duration_o),
    .busy_now_o             (busy_now_o),
    .table_full_o           (table_full_o)
  );

  // 8 ns clock
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("energy_detect_busy_duration_tb: errors");
      $finish;
    end
  end

  // result side: random stalls, plus a long hold-off when kicked
  always @(posedge clk_i) begin
    if (hold_kick != hold_seen) begin
      hold_seen = hold_kick;
      hold_left = 3000;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watch accepted words on all three channels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.thr = cfg_energy_threshold_i;
      if (in_valid_i && in_ready_o)
        sb.note_request(ebdd_pkg::req_e'(req_type_i), now_time_i, end_time_i, rx_power_i,
                        receiving_i);
      if (out_valid_o && out_ready_i) sb.check_result(busy_duration_o, busy_now_o, table_full_o);
    end
  end

  function automatic logic [47:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // offer one request word; valid stays up across back-to-back words
  task automatic send(ebdd_pkg::req_e req, logic [47:0] now, logic [47:0] endt,
                      logic [47:0] pw, logic recv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= req;
    now_time_i  <= now;
    end_time_i  <= endt;
    rx_power_i  <= pw;
    receiving_i <= recv;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.want_dur.size() != 0) @(posedge clk_i);
    repeat (900) @(posedge clk_i);
  endtask

  task automatic write_thr(logic [47:0] v);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_energy_threshold_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // power levels straddling the threshold, occasionally huge
  function automatic logic [47:0] pick_power();
    case ($urandom_range(3))
      0: return 48'($urandom_range(700000000, 100000000));
      1: return 48'($urandom_range(2000000000, 300000000));
      2: return 48'($urandom_range(1000));
      default: return rand48();
    endcase
  endfunction

  task automatic random_phase(int count);
    logic [47:0] now;
    int          pick;
    for (int n = 0; n < count; n++) begin
      tcur += $urandom_range(40);
      now = tcur + $urandom_range(20);
      pick = $urandom_range(99);
      if (pick < 55) begin
        send(ebdd_pkg::REQ_APPEND, tcur,
             ($urandom_range(9) == 0) ? tcur - $urandom_range(30) : tcur + $urandom_range(300),
             pick_power(), $urandom_range(4) == 0);
      end else if (pick < 90) begin
        send(ebdd_pkg::REQ_QUERY, now, rand48(), rand48(), $urandom_range(1));
      end else if (pick < 94) begin
        send(ebdd_pkg::REQ_ERASE, now, rand48(), rand48(), $urandom_range(1));
      end else if (pick < 96) begin
        send(ebdd_pkg::REQ_RSVD, now, rand48(), rand48(), $urandom_range(1));
      end else begin
        send(ebdd_pkg::req_e'($urandom_range(1)), rand48(), rand48(), rand48(),
             $urandom_range(1));
      end
    end
  endtask

  initial begin
    sb = new();
    cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_kick = 1'b0;
    hold_seen = 1'b0;
    hold_left = 0;
    tcur = 48'd1000;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_energy_threshold_i = '0;
    in_valid_i = 1'b0;
    req_type_i = ebdd_pkg::REQ_APPEND;
    now_time_i = '0;
    end_time_i = '0;
    rx_power_i = '0;
    receiving_i = 1'b0;
    out_ready_i = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, every request code, special cases
    send(ebdd_pkg::REQ_QUERY, 48'd10, '0, '0, 1'b0);                       // empty table
    send(ebdd_pkg::REQ_APPEND, 48'd100, 48'd200, 48'd1000000000, 1'b0);
    send(ebdd_pkg::REQ_APPEND, 48'd100, 48'd150, 48'd1000000000, 1'b1);    // equal starts
    send(ebdd_pkg::REQ_QUERY, 48'd120, '0, '0, 1'b0);
    send(ebdd_pkg::REQ_APPEND, 48'd300, 48'd250, 48'd900000000, 1'b0);     // end before start
    send(ebdd_pkg::REQ_QUERY, 48'd300, '0, '0, 1'b0);
    send(ebdd_pkg::REQ_RSVD, 48'd300, '1, '1, 1'b1);
    send(ebdd_pkg::REQ_APPEND, '1, '0, '1, 1'b0);                          // extreme fields
    send(ebdd_pkg::REQ_QUERY, '1, '1, '1, 1'b1);
    send(ebdd_pkg::REQ_APPEND, 48'd5, '1, '1, 1'b1);
    send(ebdd_pkg::REQ_QUERY, 48'd5, '0, '0, 1'b0);
    send(ebdd_pkg::REQ_ERASE, '0, '0, '0, 1'b0);
    // fill the table while a reception holds pruning off
    for (int k = 0; k < 33; k++)
      send(ebdd_pkg::REQ_APPEND, 48'd100, 48'd200, 48'd50000000, 1'b1);
    send(ebdd_pkg::REQ_QUERY, 48'd100, '0, '0, 1'b0);
    send(ebdd_pkg::REQ_ERASE, '0, '0, '0, 1'b0);

    // random phases under different idling and stalls, with the threshold rewritten between some
    write_thr('0);
    random_phase(100);
    write_thr('1);
    send_idle_pct = 87;
    random_phase(50);
    hold_kick = ~hold_kick;                                      // long result hold-off
    send_idle_pct = 0;
    random_phase(50);
    write_thr(THR_RESET);
    recv_stall_pct = 87;
    random_phase(50);
    drain();                                                     // sender pause
    random_phase(50);
    write_thr(48'($urandom_range(1500000000, 200000000)));
    send_idle_pct = 10;
    recv_stall_pct = 10;
    random_phase(100);
    drain();

    if (sb.errors == 0 && sb.want_dur.size() == 0) begin
      $display("energy_detect_busy_duration_tb: clean");
    end else begin
      $display("energy_detect_busy_duration_tb: errors");
    end
    $finish;
  end

endmodule
